/* rtl/pato_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the parent array topological order block
package pato_pkg;

    // widest joint index or joint count that any configuration can need
    localparam int IDX_W = 6;

    // depth of the command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // input transaction
    typedef struct packed {
        logic signed [5:0] parent_index;
        logic              last_joint;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [4:0] joint_index;
        logic       joint_valid;
        logic       cycle_found;
        logic       run_end;
    } t_out;

    // classified joint handed from front to back
    typedef struct packed {
        logic              store;
        logic [IDX_W-1:0]  idx;
        logic signed [5:0] parent;
        logic              last;
        logic [IDX_W-1:0]  count;
    } t_cmd;

endpackage

/* rtl/pato_front.sv */
`timescale 1ns / 1ps
// front end: accepts joints, assigns slots and marks dropped and final joints
module pato_front import pato_pkg::*; #(
    parameter int MAX_JOINTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_cmd
);

    localparam int CW = $clog2(MAX_JOINTS + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] w_cnt_inc;
    logic          w_room;

    assign w_room     = r_cnt < CW'(MAX_JOINTS);
    assign w_cnt_inc  = r_cnt + CW'(1);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.store  = w_room;
        o_cmd.idx    = IDX_W'(r_cnt);
        o_cmd.parent = i_in_data.parent_index;
        o_cmd.last   = i_in_data.last_joint;
        o_cmd.count  = w_room ? IDX_W'(w_cnt_inc) : IDX_W'(r_cnt);
    end

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_in_data.last_joint) begin
                n_cnt = '0;
            end else if (w_room) begin
                n_cnt = w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/pato_queue.sv */
`timescale 1ns / 1ps
// short command queue between front and back
module pato_queue import pato_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd           r_slot [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_fill;
    logic           w_push;
    logic           w_pop;

    assign o_full  = r_fill == (QAW + 1)'(QDEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + (QAW + 1)'(1);
                2'b01:   r_fill <= r_fill - (QAW + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* rtl/pato_back.sv */
`timescale 1ns / 1ps
// back end: parent store, done marks and the sweep sequencer with output register
module pato_back import pato_pkg::*; #(
    parameter int MAX_JOINTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int CW   = $clog2(MAX_JOINTS + 1);
    localparam int IW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_EVAL   = 2'd2;
    localparam logic [1:0] S_STATUS = 2'd3;

    logic signed [5:0]     r_mem [MAX_JOINTS];
    logic signed [5:0]     r_par;
    logic [1:0]            r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_n, n_n;
    logic [CW-1:0]         r_emit, n_emit;
    logic                  r_swp, n_swp;
    logic [MAX_JOINTS-1:0] r_done, n_done;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                  w_free;
    logic                  w_emit;
    t_out                  w_res;
    logic [CMPW-1:0]       w_p_ext;
    logic [IW-1:0]         w_p_idx;
    logic                  w_in_range;
    logic                  w_ready;
    logic                  w_last_idx;
    logic [CW-1:0]         w_emit_inc;

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign w_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // readiness of the joint under the sweep pointer
    assign w_p_ext    = CMPW'(r_par[4:0]);
    assign w_p_idx    = w_p_ext[IW-1:0];
    assign w_in_range = w_p_ext < CMPW'(r_n);
    assign w_ready    = !r_done[r_idx] &&
                        (r_par[5] || (w_in_range && r_done[w_p_idx]));
    assign w_last_idx = CW'(r_idx) == (r_n - CW'(1));
    assign w_emit_inc = r_emit + CW'(1);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_emit  = r_emit;
        n_swp   = r_swp;
        n_done  = r_done;
        w_emit  = 1'b0;
        w_res   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_cmd.last) begin
                    n_n     = i_q_cmd.count[CW-1:0];
                    n_idx   = '0;
                    n_emit  = '0;
                    n_swp   = 1'b0;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!w_ready || w_free) begin
                    if (w_ready) begin
                        w_emit            = 1'b1;
                        n_done[r_idx]     = 1'b1;
                        n_emit            = w_emit_inc;
                        w_res.joint_index = 5'(r_idx);
                        w_res.joint_valid = 1'b1;
                        w_res.run_end     = w_emit_inc == r_n;
                    end
                    if (n_emit == r_n) begin
                        n_state = S_IDLE;
                        n_done  = '0;
                        n_emit  = '0;
                    end else if (w_last_idx) begin
                        if (r_swp || w_ready) begin
                            n_idx = '0;
                            n_swp = 1'b0;
                        end else begin
                            n_state = S_STATUS;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                        n_swp = r_swp || w_ready;
                    end
                end
            end
            S_STATUS: begin
                if (w_free) begin
                    w_emit            = 1'b1;
                    w_res.cycle_found = 1'b1;
                    w_res.run_end     = 1'b1;
                    n_state           = S_IDLE;
                    n_done            = '0;
                    n_emit            = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // parent store: written while loading, read one entry ahead of the sweep
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.store) begin
            r_mem[i_q_cmd.idx[IW-1:0]] <= i_q_cmd.parent;
        end
        r_par <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_n         <= '0;
            r_emit      <= '0;
            r_swp       <= 1'b0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_emit  <= n_emit;
            r_swp   <= n_swp;
            r_done  <= n_done;
            if (w_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out <= w_res;
        end
    end

`ifndef SYNTH
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= r_n)
        else $error("emitted count passed joint count");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_done == '0 && r_emit == '0))
        else $error("done marks not cleared between runs");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.joint_valid) |->
            (o_out_data.cycle_found && o_out_data.run_end && o_out_data.joint_index == '0))
        else $error("malformed status transaction");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> ($past(r_state) == S_IDLE))
        else $error("queue popped during ordering");
`endif

endmodule

/* rtl/parent_array_topological_order.sv */
`timescale 1ns / 1ps
// top level: parent array topological order with decoupled load front and sweep back
// Joints arrive one per transaction as the signed index of their parent (negative
// means root); the joint marked last closes the skeleton, and joints past MAX_JOINTS
// are dropped. The front assigns each joint its slot and hands it through a four-entry
// command queue, so the input keeps flowing while the back is busy until the queue
// fills. Once the last joint reaches the back, the sequencer sweeps the parent store
// in ascending order, one joint visit per cycle while the output is not stalled,
// through the single read port of the store; a joint is sent out, and marked done at
// once, when it is a root or its parent is in range and already done. A run over n
// joints passes through a start state and then takes up to about n sweeps, longer while
// the output is stalled. Every joint of a sound skeleton comes out once with
// run_end on the last; if a sweep sends nothing (a cycle or a parent at or above the
// joint count) one status transaction with cycle_found and run_end closes the run.
module parent_array_topological_order import pato_pkg::*; #(
    parameter int MAX_JOINTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // front to queue
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;

    // queue to back
    logic w_q_valid;
    logic w_pop;
    t_cmd w_q_cmd;

    // slot assignment, drop and end-of-skeleton marking
    pato_front #(
        .MAX_JOINTS(MAX_JOINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // decouples loading from the sweeps
    pato_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    // parent store, done marks, sweep sequencer and output register
    pato_back #(
        .MAX_JOINTS(MAX_JOINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* bench/joint_order_checker.sv */
`timescale 1ns / 1ps
// checker that predicts the joint order of each skeleton and compares the output transactions
module joint_order_checker import pato_pkg::*; #(
    parameter int MAX_JOINTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    logic signed [5:0] parent_mem [MAX_JOINTS];
    int                stored_joints = 0;
    t_out              expected_joints [$];
    int                fails = 0;

    // store one joint, and on the last one sweep the forest into order
    task automatic order_skeleton(input t_in txn);
        int   n;
        int   sweep;
        int   emit_start;
        int   emitted;
        int   p;
        logic done [MAX_JOINTS];
        t_out res;
        if (stored_joints < MAX_JOINTS) begin
            parent_mem[stored_joints] = txn.parent_index;
            stored_joints++;
        end
        if (!txn.last_joint) return;
        n       = stored_joints;
        emitted = 0;
        for (int i = 0; i < MAX_JOINTS; i++) done[i] = 1'b0;
        for (sweep = 0; sweep < n && emitted < n; sweep++) begin
            emit_start = emitted;
            for (int i = 0; i < n; i++) begin
                if (!done[i]) begin
                    p = parent_mem[i];
                    if (p < 0 || (p < n && done[p])) begin
                        done[i] = 1'b1;
                        emitted++;
                        res.joint_index = i[4:0];
                        res.joint_valid = 1'b1;
                        res.cycle_found = 1'b0;
                        res.run_end     = (emitted == n);
                        expected_joints.push_back(res);
                    end
                end
            end
            if (emitted == emit_start) break;
        end
        // joints left over mean a cycle or a parent out of range
        if (emitted != n) begin
            res.joint_index = '0;
            res.joint_valid = 1'b0;
            res.cycle_found = 1'b1;
            res.run_end     = 1'b1;
            expected_joints.push_back(res);
        end
        stored_joints = 0;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_txn;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) order_skeleton(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_joints.size() == 0) begin
                    $error("output transaction with nothing expected");
                    fails++;
                end else begin
                    exp_txn = expected_joints.pop_front();
                    check_field("joint_index", exp_txn.joint_index, i_out_data.joint_index);
                    check_field("joint_valid", exp_txn.joint_valid, i_out_data.joint_valid);
                    check_field("cycle_found", exp_txn.cycle_found, i_out_data.cycle_found);
                    check_field("run_end", exp_txn.run_end, i_out_data.run_end);
                end
            end
        end
        o_pending    <= expected_joints.size();
        o_fail_count <= fails;
    end

endmodule

/* bench/tb_parent_array_topological_order.sv */
`timescale 1ns / 1ps
// top of the bench: clock, reset, skeleton stimulus, output stalls and the verdict
module tb_parent_array_topological_order;
    import pato_pkg::*;

    localparam int MAX_JOINTS   = 32;
    localparam int RANDOM_ITEMS = 440;
    // worst run is about 32 sweeps over 32 joints plus stalls, drain well past that
    localparam int DRAIN_CYCLES = 1500;
    localparam int CYCLE_LIMIT  = 300000;

    // skeleton shapes for the random part
    typedef enum int {
        SHAPE_FOREST,
        SHAPE_BROKEN
    } t_shape;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out out_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int rand_target;
    int plist [$];

    parent_array_topological_order #(
        .MAX_JOINTS(MAX_JOINTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (out_data)
    );

    joint_order_checker #(
        .MAX_JOINTS(MAX_JOINTS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern: free-flowing, sparse random, or long holds
    int stall_mode  = 0;
    int mode_timer  = 0;
    int hold_left   = 0;
    always @(posedge i_clk) begin
        logic next_stall;
        if (mode_timer == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_timer = $urandom_range(20, 200);
        end else begin
            mode_timer--;
        end
        next_stall = 1'b0;
        case (stall_mode)
            0: begin
                next_stall = 1'b0;
            end
            1: begin
                next_stall = ($urandom_range(0, 2) == 0);
            end
            default: begin
                // hold stall for a stretch, then release for a stretch
                if (hold_left == 0) hold_left = $urandom_range(1, 8);
                hold_left--;
                next_stall = (mode_timer % 12) < 6;
            end
        endcase
        i_out_stall <= next_stall;
    end

    // one joint transaction, with burst and gap pacing on the sender side
    task automatic send_joint(input logic signed [5:0] parent, input logic last);
        t_in txn;
        int  gap;
        txn.parent_index = parent;
        txn.last_joint   = last;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        in_data    <= txn;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        items_sent++;
    endtask

    // send the parents held in plist, last mark on the final one
    task automatic send_list();
        for (int k = 0; k < plist.size(); k++) send_joint(6'(plist[k]), k == plist.size() - 1);
    endtask

    // random skeleton of n joints; forests use a shuffled order so forward references
    // need several sweeps, broken ones get one or two parents corrupted
    task automatic send_skeleton(input int n, input t_shape shape);
        int                order   [64];
        logic signed [5:0] parents [64];
        int                j;
        int                tmp;
        int                victim;
        for (int k = 0; k < n; k++) order[k] = k;
        for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(0, 3) == 0)
                parents[order[k]] = 6'($urandom_range(0, 31) - 32);
            else
                parents[order[k]] = 6'(order[$urandom_range(0, k - 1)]);
        end
        if (shape == SHAPE_BROKEN) begin
            repeat ($urandom_range(1, 2)) begin
                victim = $urandom_range(0, n - 1);
                case ($urandom_range(0, 2))
                    0: parents[victim] = 6'($urandom_range(0, 63));
                    1: parents[victim] = 6'(victim);
                    default: parents[victim] = 6'($urandom_range(n, 31));
                endcase
            end
        end
        plist = {};
        for (int k = 0; k < n; k++) plist.push_back(int'(parents[k]));
        send_list();
    endtask

    initial begin
        int     sel;
        int     n;
        t_shape shape;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        in_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone root
        plist = '{-1};
        send_list();
        // plain chain in index order
        plist = '{-1, 0, 1};
        send_list();
        // reversed chain with the root last
        plist = '{2, 0, -1};
        send_list();
        // joint that is its own parent
        plist = '{0};
        send_list();
        // two-joint loop beside a root
        plist = '{1, 0, -1};
        send_list();
        // extreme parents, the top one out of range
        plist = '{-32, 31};
        send_list();
        // out-of-range parent in the middle
        plist = '{-1, 5, 0};
        send_list();
        // several roots
        plist = '{-1, -1, 1, 0, -16};
        send_list();

        // random skeletons, mostly small, a few full and a few overflowing the store
        rand_target = items_sent + RANDOM_ITEMS;
        while (items_sent < rand_target) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)      n = $urandom_range(1, 8);
            else if (sel < 86) n = $urandom_range(9, 20);
            else if (sel < 94) n = MAX_JOINTS;
            else               n = $urandom_range(MAX_JOINTS + 1, MAX_JOINTS + 3);
            shape = ($urandom_range(0, 4) == 0) ? SHAPE_BROKEN : SHAPE_FOREST;
            send_skeleton(n, shape);
        end
        i_in_valid <= 1'b0;

        // let the checker see the final transaction before asking it what is left
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/pato_pkg.sv
rtl/pato_front.sv
rtl/pato_queue.sv
rtl/pato_back.sv
rtl/parent_array_topological_order.sv
bench/joint_order_checker.sv
bench/tb_parent_array_topological_order.sv
